// ===== hdl/pbri_pkg.sv =====
// Shared types and constants of the prime-base radical inverse block.
// Holds the prime table, the sequencer states and the divider command.
// Has no dependencies; the sequencer and the divider import it.
`timescale 1ns / 1ps

package pbri_pkg;

    localparam int WORD_W    = 64;   // width of a sample index
    localparam int DIGIT_W   = 9;    // wide enough for any digit of the largest prime
    localparam int STEP_BITS = 8;    // quotient bits per run cycle of the shared divider
    localparam int CYC_W     = 3;    // holds the longest run of divider cycles, less one
    localparam int CNT_W     = 7;    // holds a digit count of 0 to 64
    localparam int ADDR_W    = 6;    // addresses one of 64 stored digits
    localparam int ROM_SIZE  = 64;
    localparam int INDEX_W   = 6;
    localparam int DIGIT_CYC = WORD_W / STEP_BITS;

    localparam logic [DIGIT_W-1:0] PRIME_ROM [0:ROM_SIZE-1] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
        9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
        9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
        9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
        9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
        9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
        9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTRACT,
        S_DIGIT,
        S_READ,
        S_LOAD,
        S_FOLD,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic run;
    } t_div_cmd;

endpackage

// ===== hdl/prime_base_radical_inverse.sv =====
// Prime-base radical inverse: sequencer, digit store and result register.
// Depends on pbri_pkg, pbri_div and pbri_ram.
//
// Use: an input beat carries a prime-table index and a 64-bit sample index;
// the output beat carries floor(2^FRACTION_BITS * reversed / b^k), the base-b
// digits of the sample mirrored about the radix point. A zero sample gives 0.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. o_stall is high from the accepting edge until the sequencer
// returns to idle, so one item is in work at a time.
// Steps: the shared divider peels each base-b digit off the sample, and the
// digit is stored; later the same divider folds the digits back in, the most
// significant first, each after the digit store's registered read.
// The finished result sits in an output register; a new beat is taken while
// it waits, and the sequencer only holds in its final state if that register
// is still full and stalled when the next result is ready. Reset empties the
// output register and returns the sequencer to idle.
`timescale 1ns / 1ps

module prime_base_radical_inverse #(
    parameter int PRIME_COUNT   = 64,
    parameter int FRACTION_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pbri_pkg::INDEX_W-1:0]      i_base_index,
    input  logic [pbri_pkg::WORD_W-1:0]       i_sample_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [FRACTION_BITS-1:0]          o_fraction
);

    import pbri_pkg::*;

    localparam int FOLD_BITS  = DIGIT_W + FRACTION_BITS;
    localparam int FOLD_CYC   = (FOLD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int FOLD_SHIFT = WORD_W - FOLD_CYC * STEP_BITS;
    localparam logic [FRACTION_BITS-1:0] FRAC_MAX = '1;

    t_state                  r_state, n_state;
    logic [CYC_W-1:0]        r_cyc, n_cyc;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        cnt_dec;
    logic [DIGIT_W-1:0]      r_base, n_base;
    logic [FRACTION_BITS-1:0] r_acc, n_acc;
    logic                    r_out_valid, n_out_valid;
    logic [FRACTION_BITS-1:0] r_fraction, n_fraction;

    logic [INDEX_W-1:0]      idx_sel;
    t_div_cmd                div_cmd;
    logic [WORD_W-1:0]       div_load_word;
    logic [WORD_W-1:0]       div_word;
    logic [DIGIT_W-1:0]      div_rem;
    logic                    ram_we;
    logic [DIGIT_W-1:0]      ram_rdata;
    logic                    out_free;
    logic [FRACTION_BITS-1:0] quot;

    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign out_free = !r_out_valid || !i_stall;
    assign idx_sel  = (int'(i_base_index) >= PRIME_COUNT) ?
                      INDEX_W'(PRIME_COUNT - 1) : i_base_index;

    // The fold quotient is always below 2^FRACTION_BITS; the clamp is the
    // usual one-minus-epsilon guard.
    assign quot = (|div_word[WORD_W-1:FRACTION_BITS]) ? FRAC_MAX :
                  div_word[FRACTION_BITS-1:0];

    pbri_div u_div (
        .i_clk       (i_clk),
        .i_cmd       (div_cmd),
        .i_load_word (div_load_word),
        .i_base      (r_base),
        .o_word      (div_word),
        .o_rem       (div_rem)
    );

    pbri_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (ROM_SIZE)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_raddr (cnt_dec[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_sample_index == '0) ? S_DONE : S_EXTRACT;
                end
            end
            S_EXTRACT: begin
                if (r_cyc == CYC_W'(DIGIT_CYC - 1)) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (div_word == '0 || r_cnt == CNT_W'(WORD_W - 1)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_EXTRACT;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (r_cyc == CYC_W'(FOLD_CYC - 1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = (r_cnt == '0) ? S_DONE : S_LOAD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer and next values of the datapath registers.
    always_comb begin
        div_cmd       = '0;
        div_load_word = i_sample_index;
        ram_we        = 1'b0;
        n_cyc         = '0;
        n_cnt         = r_cnt;
        n_base        = r_base;
        n_acc         = r_acc;
        n_out_valid   = r_out_valid && i_stall;
        n_fraction    = r_fraction;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    div_cmd.load = 1'b1;
                    n_cnt        = '0;
                    n_acc        = '0;
                    n_base       = PRIME_ROM[idx_sel];
                end
            end
            S_EXTRACT: begin
                div_cmd.run = 1'b1;
                n_cyc       = r_cyc + CYC_W'(1);
            end
            S_DIGIT: begin
                // Store the digit and restart on the quotient with a clear
                // remainder.
                ram_we        = 1'b1;
                div_cmd.load  = 1'b1;
                div_load_word = div_word;
                n_cnt         = r_cnt + CNT_W'(1);
            end
            S_LOAD: begin
                // Dividend is digit * 2^F + acc, left-aligned in the divider.
                div_cmd.load  = 1'b1;
                div_load_word = WORD_W'({ram_rdata, r_acc}) << FOLD_SHIFT;
                n_cnt         = cnt_dec;
            end
            S_FOLD: begin
                div_cmd.run = 1'b1;
                n_cyc       = r_cyc + CYC_W'(1);
            end
            S_NEXT: begin
                n_acc = quot;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_fraction  = r_acc;
                end
            end
            default: begin
                div_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cyc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cyc       <= n_cyc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_acc      <= n_acc;
        r_fraction <= n_fraction;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_fraction = r_fraction;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after taking a beat");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WORD_W))
        else $error("digit count beyond 64");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXTRACT || r_state == S_FOLD) |-> (div_rem < r_base))
        else $error("divider remainder not below the base");

    a_fold_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (div_word[WORD_W-1:FRACTION_BITS] == '0))
        else $error("fold quotient overflowed the fraction");

endmodule

// ===== hdl/pbri_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pbri_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pbri_div.sv =====
// Shared restoring divider: while run is set, a 64-bit dividend shifts out at
// the top and eight quotient bits a cycle shift in at the bottom.
// The divisor is a prime. Depends on pbri_pkg.
`timescale 1ns / 1ps

module pbri_div (
    input  logic                            i_clk,
    input  pbri_pkg::t_div_cmd              i_cmd,
    input  logic [pbri_pkg::WORD_W-1:0]     i_load_word,
    input  logic [pbri_pkg::DIGIT_W-1:0]    i_base,
    output logic [pbri_pkg::WORD_W-1:0]     o_word,
    output logic [pbri_pkg::DIGIT_W-1:0]    o_rem
);

    import pbri_pkg::*;

    logic [WORD_W-1:0]    r_word;
    logic [DIGIT_W-1:0]   r_rem;
    logic [WORD_W-1:0]    n_word;
    logic [DIGIT_W-1:0]   n_rem;
    logic [DIGIT_W:0]     trial;
    logic [DIGIT_W-1:0]   rem;
    logic [STEP_BITS-1:0] qbits;

    // The remainder stays below the divisor, so each trial fits in ten bits.
    always_comb begin
        rem   = r_rem;
        trial = '0;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem, r_word[WORD_W-1-i]};
            if (trial >= {1'b0, i_base}) begin
                qbits[STEP_BITS-1-i] = 1'b1;
                rem = DIGIT_W'(trial - {1'b0, i_base});
            end else begin
                qbits[STEP_BITS-1-i] = 1'b0;
                rem = trial[DIGIT_W-1:0];
            end
        end
        n_rem  = rem;
        n_word = {r_word[WORD_W-STEP_BITS-1:0], qbits};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_load_word;
            r_rem  <= '0;
        end else if (i_cmd.run) begin
            r_word <= n_word;
            r_rem  <= n_rem;
        end
    end

    assign o_word = r_word;
    assign o_rem  = r_rem;

endmodule
